// ===== rtl/core/fccs_pkg.sv =====
package fccs_pkg;

   localparam int TABLE_BYTES_DEFAULT = 65536;

   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = 16;
   localparam int CLUSTER_W = 28;
   localparam int WORD_W    = 32;
   localparam int KIND_W    = 2;
   localparam int SPC_W     = 8;
   localparam int CSR_IDX_W = 2;

   // byte lanes of the table store, one per byte of a 32-bit entry
   localparam int LANES  = 4;
   localparam int LANE_W = 2;

   // entry byte offset: 4 * cluster plus 3 needs 30 bits; LO_W gives 31
   localparam int LO_W = 31;

   localparam logic [11:0] EOC_FAT12 = 12'hFF8;
   localparam logic [15:0] EOC_FAT16 = 16'hFFF8;
   localparam logic [27:0] EOC_FAT32 = 28'hFFF_FFF8;
   localparam int          FAT32_W   = 28;

   typedef enum logic [KIND_W-1:0] {
      KIND_FAT12 = 2'd0,
      KIND_FAT16 = 2'd1,
      KIND_FAT32 = 2'd2
   } fat_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAT_KIND    = 2'd0,
      CSR_SECTORS     = 2'd1,
      CSR_BASE_SECTOR = 2'd2
   } csr_index_type;

   typedef enum logic {
      ACT_WRITE  = 1'b0,
      ACT_LOOKUP = 1'b1
   } action_type;

   typedef struct packed {
      logic              enable;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } wr_req_type;

   typedef struct packed {
      logic            enable;
      logic [LO_W-1:0] lo;
   } rd_req_type;

endpackage

// ===== rtl/core/fccs_store.sv =====
module fccs_store #(
   parameter int TABLE_BYTES = fccs_pkg::TABLE_BYTES_DEFAULT
) (
   input  logic                                                clock,
   input  fccs_pkg::wr_req_type                                wr,
   input  fccs_pkg::rd_req_type                                rd,
   output logic [fccs_pkg::LANES-1:0][fccs_pkg::BYTE_W-1:0]    rd_bytes
);

   localparam int BANK_DEPTH = (TABLE_BYTES + fccs_pkg::LANES - 1) / fccs_pkg::LANES;
   localparam int ROW_W      = $clog2(BANK_DEPTH);

   logic [ROW_W-1:0] rd_base;
   logic [ROW_W-1:0] rd_next;
   logic [ROW_W-1:0] wr_row;
   logic [fccs_pkg::LANES-1:0][fccs_pkg::BYTE_W-1:0] bank_q;
   logic [fccs_pkg::LANE_W-1:0] rot_ff;

   assign rd_base = ROW_W'(rd.lo >> fccs_pkg::LANE_W);
   assign rd_next = rd_base + ROW_W'(1);
   assign wr_row  = ROW_W'(wr.addr >> fccs_pkg::LANE_W);

   // lane b holds bytes with address mod 4 == b; lanes below the start
   // offset come from the following row
   for (genvar b = 0; b < fccs_pkg::LANES; b++) begin : g_bank
      logic [fccs_pkg::BYTE_W-1:0] mem [BANK_DEPTH];
      logic [fccs_pkg::BYTE_W-1:0] q_ff;
      logic [ROW_W-1:0]            rrow;

      assign rrow = (fccs_pkg::LANE_W'(b) < rd.lo[fccs_pkg::LANE_W-1:0]) ? rd_next : rd_base;

      always_ff @(posedge clock) begin
         if (wr.enable && (wr.addr[fccs_pkg::LANE_W-1:0] == fccs_pkg::LANE_W'(b))) begin
            mem[wr_row] <= wr.data;
         end
         if (rd.enable) begin
            q_ff <= mem[rrow];
         end
      end

      assign bank_q[b] = q_ff;
   end

   always_ff @(posedge clock) begin
      if (rd.enable) begin
         rot_ff <= rd.lo[fccs_pkg::LANE_W-1:0];
      end
   end

   always_comb begin
      for (int k = 0; k < fccs_pkg::LANES; k++) begin
         rd_bytes[k] = bank_q[fccs_pkg::LANE_W'(rot_ff + fccs_pkg::LANE_W'(k))];
      end
   end

endmodule

// ===== rtl/core/fat_cluster_chain_step_top.sv =====
// FAT12/FAT16/FAT32 cluster chain lookup.
// Input channel: start with req_action, req_byte_address, req_byte_value and
// req_cluster_number; a transfer happens at a clock edge with start high and
// busy low. Action write stores one table byte, if its address lies in the
// table, and gives no result; action lookup gives one result.
// Result channel: rsp_valid marks a result for exactly one cycle; the
// receiver cannot stall it, so the block never waits on the output side.
// Configuration: csr_write_enable, csr_index, csr_write_data; the user must
// write it only while no lookup is in flight; the block does not enforce this.
// A lookup passes the stage 1, stage 2 and result registers before the rsp_
// ports show it. Throughput: one item per cycle while reset is low; the table
// store has four byte lanes, one read port each, so every entry is one access.
// A lookup right after a byte write sees that byte.
// Reset (synchronous) clears the pipeline and the configuration; busy is
// high while reset is high. The table contents are undefined until written.
module fat_cluster_chain_step_top #(
   parameter int TABLE_BYTES = fccs_pkg::TABLE_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [fccs_pkg::ADDR_W-1:0]       req_byte_address,
   input  logic [fccs_pkg::BYTE_W-1:0]       req_byte_value,
   input  logic [fccs_pkg::CLUSTER_W-1:0]    req_cluster_number,
   output logic                              rsp_valid,
   output logic [fccs_pkg::WORD_W-1:0]       rsp_first_sector,
   output logic [fccs_pkg::WORD_W-1:0]       rsp_next_cluster,
   output logic                              rsp_end_of_chain,
   output logic                              rsp_bad_value,
   output logic                              rsp_out_of_range,
   input  logic                              csr_write_enable,
   input  logic [fccs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fccs_pkg::WORD_W-1:0]       csr_write_data
);

   localparam int LO_W = fccs_pkg::LO_W;
   localparam int W    = fccs_pkg::WORD_W;

   // configuration
   logic [fccs_pkg::KIND_W-1:0] cfg_kind_ff;
   logic [fccs_pkg::SPC_W-1:0]  cfg_spc_ff;
   logic [W-1:0]                cfg_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_kind_ff  <= fccs_pkg::KIND_FAT12;
         cfg_spc_ff   <= fccs_pkg::SPC_W'(1);
         cfg_start_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (fccs_pkg::csr_index_type'(csr_index))
            fccs_pkg::CSR_FAT_KIND: begin
               cfg_kind_ff <= csr_write_data[fccs_pkg::KIND_W-1:0];
            end
            fccs_pkg::CSR_SECTORS: begin
               cfg_spc_ff <= csr_write_data[fccs_pkg::SPC_W-1:0];
            end
            fccs_pkg::CSR_BASE_SECTOR: begin
               cfg_start_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign busy = reset;

   // stage 0: entry address and range check
   logic                accept;
   logic [26:0]         half;
   logic [LO_W-1:0]     lo_in;
   logic [LO_W-1:0]     last_in;
   logic                oor_in;
   logic                wr_ok_in;

   assign accept   = start && !busy;
   assign half     = req_cluster_number[fccs_pkg::CLUSTER_W-1:1];
   assign wr_ok_in = W'(req_byte_address) < W'(TABLE_BYTES);

   always_comb begin
      if (cfg_kind_ff == fccs_pkg::KIND_FAT12) begin
         lo_in   = LO_W'(half) + LO_W'({half, 1'b0});
         last_in = lo_in + (req_cluster_number[0] ? LO_W'(2) : LO_W'(1));
      end else if (cfg_kind_ff == fccs_pkg::KIND_FAT16) begin
         lo_in   = LO_W'({req_cluster_number, 1'b0});
         last_in = lo_in + LO_W'(1);
      end else begin
         lo_in   = LO_W'({req_cluster_number, 2'b00});
         last_in = lo_in + LO_W'(3);
      end
      oor_in = last_in >= LO_W'(TABLE_BYTES);
   end

   // stage 1
   logic                        s1_look_ff;
   logic                        s1_wr_ff;
   logic [LO_W-1:0]             s1_lo_ff;
   logic                        s1_oor_ff;
   logic                        s1_odd_ff;
   logic [W-1:0]                s1_sub_ff;
   logic [fccs_pkg::ADDR_W-1:0] s1_addr_ff;
   logic [fccs_pkg::BYTE_W-1:0] s1_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_look_ff <= 1'b0;
         s1_wr_ff   <= 1'b0;
      end else begin
         s1_look_ff <= accept && (req_action == fccs_pkg::ACT_LOOKUP);
         s1_wr_ff   <= accept && (req_action == fccs_pkg::ACT_WRITE) && wr_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_lo_ff   <= lo_in;
      s1_oor_ff  <= oor_in;
      s1_odd_ff  <= req_cluster_number[0];
      s1_sub_ff  <= W'(req_cluster_number) - W'(2);
      s1_addr_ff <= req_byte_address;
      s1_data_ff <= req_byte_value;
   end

   fccs_pkg::wr_req_type wr_req;
   fccs_pkg::rd_req_type rd_req;
   logic [fccs_pkg::LANES-1:0][fccs_pkg::BYTE_W-1:0] entry_bytes;

   assign wr_req.enable = s1_wr_ff;
   assign wr_req.addr   = s1_addr_ff;
   assign wr_req.data   = s1_data_ff;
   assign rd_req.enable = s1_look_ff && !s1_oor_ff;
   assign rd_req.lo     = s1_lo_ff;

   fccs_store #(
      .TABLE_BYTES(TABLE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr      (wr_req),
      .rd      (rd_req),
      .rd_bytes(entry_bytes)
   );

   // stage 2: store read and sector product
   logic         s2_look_ff;
   logic         s2_oor_ff;
   logic         s2_odd_ff;
   logic [W-1:0] s2_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_look_ff <= 1'b0;
      end else begin
         s2_look_ff <= s1_look_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_oor_ff  <= s1_oor_ff;
      s2_odd_ff  <= s1_odd_ff;
      s2_prod_ff <= s1_sub_ff * W'(cfg_spc_ff);
   end

   // stage 3: decode, flags and sector sum
   logic [W-1:0] entry_in;
   logic         eoc_in;
   logic [W-1:0] sector_in;

   always_comb begin
      if (cfg_kind_ff == fccs_pkg::KIND_FAT12) begin
         if (s2_odd_ff) begin
            entry_in = W'({entry_bytes[2], entry_bytes[1][7:4]});
         end else begin
            entry_in = W'({entry_bytes[1][3:0], entry_bytes[0]});
         end
         eoc_in = entry_in[11:0] >= fccs_pkg::EOC_FAT12;
      end else if (cfg_kind_ff == fccs_pkg::KIND_FAT16) begin
         entry_in = W'({entry_bytes[1], entry_bytes[0]});
         eoc_in   = entry_in[15:0] >= fccs_pkg::EOC_FAT16;
      end else begin
         entry_in = {entry_bytes[3], entry_bytes[2], entry_bytes[1], entry_bytes[0]};
         eoc_in   = entry_in[fccs_pkg::FAT32_W-1:0] >= fccs_pkg::EOC_FAT32;
      end
      sector_in = s2_prod_ff + cfg_start_ff;
   end

   logic         rsp_valid_ff;
   logic [W-1:0] rsp_sector_ff;
   logic [W-1:0] rsp_next_ff;
   logic         rsp_eoc_ff;
   logic         rsp_bad_ff;
   logic         rsp_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_look_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_oor_ff) begin
         rsp_sector_ff <= '0;
         rsp_next_ff   <= '0;
         rsp_eoc_ff    <= 1'b0;
         rsp_bad_ff    <= 1'b0;
      end else begin
         rsp_sector_ff <= sector_in;
         rsp_next_ff   <= entry_in;
         rsp_eoc_ff    <= eoc_in;
         rsp_bad_ff    <= !eoc_in && (entry_in < W'(2));
      end
      rsp_oor_ff <= s2_oor_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_sector = rsp_sector_ff;
   assign rsp_next_cluster = rsp_next_ff;
   assign rsp_end_of_chain = rsp_eoc_ff;
   assign rsp_bad_value    = rsp_bad_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

// ===== rtl/core/fccs_checker.sv =====
module fccs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              req_action,
   input logic                              rsp_valid,
   input logic [fccs_pkg::WORD_W-1:0]       rsp_first_sector,
   input logic [fccs_pkg::WORD_W-1:0]       rsp_next_cluster,
   input logic                              rsp_end_of_chain,
   input logic                              rsp_bad_value,
   input logic                              rsp_out_of_range
);

   logic look_xfer;
   logic write_xfer;

   assign look_xfer  = start && !busy && (req_action == fccs_pkg::ACT_LOOKUP);
   assign write_xfer = start && !busy && (req_action == fccs_pkg::ACT_WRITE);

   a_lookup_answers: assert property (@(posedge clock) disable iff (reset)
      look_xfer |-> ##3 rsp_valid)
      else $error("lookup transfer without result");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      write_xfer |-> ##3 !rsp_valid)
      else $error("byte write produced a result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(look_xfer, 3))
      else $error("result without lookup transfer");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
         (rsp_first_sector == '0) && (rsp_next_cluster == '0) &&
         !rsp_end_of_chain && !rsp_bad_value)
      else $error("out of range result carries data");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_end_of_chain && rsp_bad_value))
      else $error("end of chain and bad value both set");

endmodule

bind fat_cluster_chain_step_top fccs_checker u_fccs_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_action      (req_action),
   .rsp_valid       (rsp_valid),
   .rsp_first_sector(rsp_first_sector),
   .rsp_next_cluster(rsp_next_cluster),
   .rsp_end_of_chain(rsp_end_of_chain),
   .rsp_bad_value   (rsp_bad_value),
   .rsp_out_of_range(rsp_out_of_range)
);

// ===== tb/sv/tb_fat_cluster_chain_step_top.sv =====
module tb_fat_cluster_chain_step_top;

   localparam int          STORE_BYTES  = fccs_pkg::TABLE_BYTES_DEFAULT;
   localparam int          RANDOM_ITEMS = 1300;
   localparam int unsigned STALL_LIMIT  = 2000;

   localparam int BYTE_W    = fccs_pkg::BYTE_W;
   localparam int ADDR_W    = fccs_pkg::ADDR_W;
   localparam int CLUSTER_W = fccs_pkg::CLUSTER_W;
   localparam int WORD_W    = fccs_pkg::WORD_W;
   localparam int KIND_W    = fccs_pkg::KIND_W;
   localparam int SPC_W     = fccs_pkg::SPC_W;
   localparam int CSR_IDX_W = fccs_pkg::CSR_IDX_W;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [KIND_W-1:0]    KIND_SPARE = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] first_sector;
      logic [WORD_W-1:0] next_cluster;
      logic              end_of_chain;
      logic              bad_value;
      logic              out_of_range;
   } lookup_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_action;
   logic [ADDR_W-1:0]    req_byte_address;
   logic [BYTE_W-1:0]    req_byte_value;
   logic [CLUSTER_W-1:0] req_cluster_number;
   logic                 rsp_valid;
   logic [WORD_W-1:0]    rsp_first_sector;
   logic [WORD_W-1:0]    rsp_next_cluster;
   logic                 rsp_end_of_chain;
   logic                 rsp_bad_value;
   logic                 rsp_out_of_range;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_write_data;

   // shadow of the table store and the registers
   logic [BYTE_W-1:0] table_image [0:STORE_BYTES-1];
   logic [KIND_W-1:0] fat_kind_cfg;
   logic [SPC_W-1:0]  spc_cfg;
   logic [WORD_W-1:0] base_sector_cfg;

   lookup_result_type expected_lookups [$];
   int unsigned       loaded_clusters [$];

   int unsigned stall_cycles    = 0;
   int          mismatch_count  = 0;
   int          items_sent      = 0;
   int          burst_left      = 0;
   int          settings_used   = 0;
   int          bytes_written   = 0;
   int          lookups_inside  = 0;
   int          lookups_outside = 0;
   int          chain_ends      = 0;
   int          bad_entries     = 0;
   int          results_checked = 0;

   fat_cluster_chain_step_top DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_byte_address   (req_byte_address),
      .req_byte_value     (req_byte_value),
      .req_cluster_number (req_cluster_number),
      .rsp_valid          (rsp_valid),
      .rsp_first_sector   (rsp_first_sector),
      .rsp_next_cluster   (rsp_next_cluster),
      .rsp_end_of_chain   (rsp_end_of_chain),
      .rsp_bad_value      (rsp_bad_value),
      .rsp_out_of_range   (rsp_out_of_range),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void entry_span(input logic [CLUSTER_W-1:0] c,
                                      output longint lo, output longint last);
      case (fat_kind_cfg)
         fccs_pkg::KIND_FAT12: begin
            lo   = 3 * longint'(c >> 1);
            last = c[0] ? lo + 2 : lo + 1;
         end
         fccs_pkg::KIND_FAT16: begin
            lo   = 2 * longint'(c);
            last = lo + 1;
         end
         default: begin
            lo   = 4 * longint'(c);
            last = lo + 3;
         end
      endcase
   endfunction

   function automatic int unsigned top_cluster_in_range();
      longint      lo;
      longint      last;
      int unsigned c;
      if (fat_kind_cfg == fccs_pkg::KIND_FAT16) return STORE_BYTES / 2 - 1;
      if (fat_kind_cfg != fccs_pkg::KIND_FAT12) return STORE_BYTES / 4 - 1;
      c = (STORE_BYTES / 3) * 2 + 2;
      entry_span(c, lo, last);
      while (last >= STORE_BYTES) begin
         c--;
         entry_span(c, lo, last);
      end
      return c;
   endfunction

   function automatic lookup_result_type predict_lookup(input logic [CLUSTER_W-1:0] c);
      lookup_result_type r;
      longint            lo;
      longint            last;
      logic [WORD_W-1:0] entry;
      r = '0;
      entry_span(c, lo, last);
      if (last >= STORE_BYTES) begin
         r.out_of_range = 1'b1;
         return r;
      end
      case (fat_kind_cfg)
         fccs_pkg::KIND_FAT12: begin
            if (!c[0])
               entry = {20'd0, table_image[lo+1][3:0], table_image[lo]};
            else
               entry = {20'd0, table_image[lo+2], table_image[lo+1][7:4]};
            r.end_of_chain = entry >= 32'h0000_0FF8;
         end
         fccs_pkg::KIND_FAT16: begin
            entry = {16'd0, table_image[lo+1], table_image[lo]};
            r.end_of_chain = entry >= 32'h0000_FFF8;
         end
         default: begin
            entry = {table_image[lo+3], table_image[lo+2], table_image[lo+1],
                     table_image[lo]};
            r.end_of_chain = entry[27:0] >= 28'hFFF_FFF8;
         end
      endcase
      r.next_cluster = entry;
      r.bad_value    = !r.end_of_chain && entry < 32'd2;
      r.first_sector = ({4'd0, c} - 32'd2) * {24'd0, spc_cfg} + base_sector_cfg;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // result checking, then shadow update for the transfer at this edge
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            results_checked++;
            if (expected_lookups.size() == 0) begin
               report_mismatch("result with no lookup pending", rsp_first_sector, '0);
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_first_sector !== want.first_sector)
                  report_mismatch("first_sector", rsp_first_sector, want.first_sector);
               if (rsp_next_cluster !== want.next_cluster)
                  report_mismatch("next_cluster", rsp_next_cluster, want.next_cluster);
               if (rsp_end_of_chain !== want.end_of_chain)
                  report_mismatch("end_of_chain", rsp_end_of_chain, want.end_of_chain);
               if (rsp_bad_value !== want.bad_value)
                  report_mismatch("bad_value", rsp_bad_value, want.bad_value);
               if (rsp_out_of_range !== want.out_of_range)
                  report_mismatch("out_of_range", rsp_out_of_range, want.out_of_range);
            end
         end
         if (start && !busy) begin
            if (req_action == fccs_pkg::ACT_WRITE) begin
               table_image[req_byte_address] = req_byte_value;
               bytes_written++;
            end else begin
               want = predict_lookup(req_cluster_number);
               expected_lookups.push_back(want);
               if (want.out_of_range) lookups_outside++;
               else lookups_inside++;
               if (want.end_of_chain) chain_ends++;
               if (want.bad_value) bad_entries++;
            end
         end
         if (rsp_valid || (start && !busy)) stall_cycles = 0;
         else stall_cycles++;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   task automatic send_item(input fccs_pkg::action_type act,
                            input logic [ADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] value,
                            input logic [CLUSTER_W-1:0] cluster);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 7);
         repeat (gap) begin
            req_action         = 1'($urandom_range(0, 1));
            req_byte_address   = ADDR_W'($urandom);
            req_byte_value     = BYTE_W'($urandom);
            req_cluster_number = CLUSTER_W'($urandom);
            @(negedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      start              = 1'b1;
      req_action         = act;
      req_byte_address   = addr;
      req_byte_value     = value;
      req_cluster_number = cluster;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_byte(input int addr, input logic [BYTE_W-1:0] value);
      send_item(fccs_pkg::ACT_WRITE, ADDR_W'(addr), value, CLUSTER_W'($urandom));
   endtask

   task automatic look_up(input logic [CLUSTER_W-1:0] cluster);
      send_item(fccs_pkg::ACT_LOOKUP, ADDR_W'($urandom), BYTE_W'($urandom), cluster);
   endtask

   // writes the bytes of one entry; FAT12 keeps the neighbor's nibble
   task automatic load_entry(input logic [CLUSTER_W-1:0] c, input logic [WORD_W-1:0] v);
      longint lo;
      longint last;
      entry_span(c, lo, last);
      case (fat_kind_cfg)
         fccs_pkg::KIND_FAT12: begin
            if (!c[0]) begin
               write_byte(lo, v[7:0]);
               write_byte(lo + 1, {table_image[lo+1][7:4], v[11:8]});
            end else begin
               write_byte(lo + 1, {v[3:0], table_image[lo+1][3:0]});
               write_byte(lo + 2, v[11:4]);
            end
         end
         fccs_pkg::KIND_FAT16: begin
            write_byte(lo, v[7:0]);
            write_byte(lo + 1, v[15:8]);
         end
         default: begin
            write_byte(lo, v[7:0]);
            write_byte(lo + 1, v[15:8]);
            write_byte(lo + 2, v[23:16]);
            write_byte(lo + 3, v[31:24]);
         end
      endcase
   endtask

   task automatic wait_idle();
      while (expected_lookups.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [WORD_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         fccs_pkg::CSR_FAT_KIND:    fat_kind_cfg    = data[KIND_W-1:0];
         fccs_pkg::CSR_SECTORS:     spc_cfg         = data[SPC_W-1:0];
         fccs_pkg::CSR_BASE_SECTOR: base_sector_cfg = data;
         default: ;
      endcase
   endtask

   // unused high bits of the narrow registers carry noise
   task automatic configure(input logic [KIND_W-1:0] kind, input logic [SPC_W-1:0] spc,
                            input logic [WORD_W-1:0] base_sector);
      wait_idle();
      write_register(fccs_pkg::CSR_FAT_KIND, {30'($urandom), kind});
      write_register(fccs_pkg::CSR_SECTORS, {24'($urandom), spc});
      write_register(fccs_pkg::CSR_BASE_SECTOR, base_sector);
      settings_used++;
   endtask

   task automatic test_fat12_decode();
      configure(fccs_pkg::KIND_FAT12, 8'd1, 32'd0);
      write_byte(0, 8'hF8);
      write_byte(1, 8'hFF);
      write_byte(2, 8'hFF);
      write_byte(3, 8'h01);
      write_byte(4, 8'h70);
      write_byte(5, 8'hFF);
      look_up(0);
      look_up(1);
      look_up(2);
      look_up(3);
      look_up(top_cluster_in_range() + 1);
   endtask

   task automatic test_fat16_decode();
      configure(fccs_pkg::KIND_FAT16, 8'd128, 32'hFFFF_FFFF);
      write_byte(4, 8'hF7);
      write_byte(5, 8'hFF);
      write_byte(6, 8'hF8);
      write_byte(7, 8'hFF);
      look_up(2);
      look_up(3);
      look_up(top_cluster_in_range() + 1);
   endtask

   task automatic test_fat32_decode();
      configure(fccs_pkg::KIND_FAT32, 8'd0, 32'h89AB_CDEF);
      write_register(CSR_UNUSED, 32'hFFFF_FFFF);
      load_entry(2, 32'hFFFF_FFF8);
      look_up(1);
      look_up(2);
      look_up(top_cluster_in_range() + 1);
      look_up(28'hFFF_FFFF);
      configure(KIND_SPARE, 8'd255, 32'h89AB_CDEF);
      look_up(2);
   endtask

   task automatic test_random_chains();
      int                   stop_at;
      int                   phase_end;
      int                   r;
      int unsigned          top;
      logic [KIND_W-1:0]    kind;
      logic [SPC_W-1:0]     spc;
      logic [WORD_W-1:0]    base_sector;
      logic [WORD_W-1:0]    v;
      logic [CLUSTER_W-1:0] c;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         kind = KIND_W'($urandom_range(0, 3));
         case ($urandom_range(0, 4))
            0:       spc = 8'd1;
            1:       spc = 8'd128;
            2:       spc = 8'd0;
            3:       spc = 8'd255;
            default: spc = SPC_W'($urandom_range(1, 128));
         endcase
         case ($urandom_range(0, 3))
            0:       base_sector = 32'd0;
            1:       base_sector = 32'hFFFF_FFFF;
            default: base_sector = $urandom;
         endcase
         configure(kind, spc, base_sector);
         top = top_cluster_in_range();
         loaded_clusters.delete();
         phase_end = items_sent + $urandom_range(120, 200);
         if (phase_end > stop_at) phase_end = stop_at;
         while (items_sent < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               case ($urandom_range(0, 9))
                  0, 1:    c = top - $urandom_range(0, 3);
                  2:       c = $urandom_range(0, 3);
                  default: c = $urandom_range(0, top);
               endcase
               v = $urandom;
               case ($urandom_range(0, 7))
                  0: v = 32'd0;
                  1: v = 32'd1;
                  2: v = 32'd2;
                  3: v = (kind == fccs_pkg::KIND_FAT12) ? 32'hFF7 :
                         (kind == fccs_pkg::KIND_FAT16) ? 32'hFFF7 :
                         {v[31:28], 28'hFFF_FFF7};
                  4: v = (kind == fccs_pkg::KIND_FAT12) ? 32'hFF8 :
                         (kind == fccs_pkg::KIND_FAT16) ? 32'hFFF8 :
                         {v[31:28], 28'hFFF_FFF8};
                  5: v = 32'hFFFF_FFFF;
                  6: v = {v[31:28], 27'd0, v[0]};
                  default: ;
               endcase
               if (kind == fccs_pkg::KIND_FAT12) v[31:12] = '0;
               else if (kind == fccs_pkg::KIND_FAT16) v[31:16] = '0;
               load_entry(c, v);
               look_up(c);
               loaded_clusters.push_back(c);
            end else if (r < 70 && loaded_clusters.size() != 0) begin
               look_up(loaded_clusters[$urandom_range(0, loaded_clusters.size() - 1)]);
            end else if (r < 85) begin
               if ($urandom_range(0, 3) == 0) look_up(top + 1);
               else look_up($urandom_range(top + 1, 28'hFFF_FFFF));
            end else begin
               write_byte($urandom_range(0, STORE_BYTES - 1), BYTE_W'($urandom));
            end
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_action         = fccs_pkg::ACT_WRITE;
      req_byte_address   = '0;
      req_byte_value     = '0;
      req_cluster_number = '0;
      csr_write_enable   = 1'b0;
      csr_index          = fccs_pkg::CSR_FAT_KIND;
      csr_write_data     = '0;
      fat_kind_cfg       = fccs_pkg::KIND_FAT12;
      spc_cfg            = 8'd1;
      base_sector_cfg    = '0;
      foreach (table_image[i]) table_image[i] = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_fat12_decode();
      test_fat16_decode();
      test_fat32_decode();
      test_random_chains();

      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d items under %0d register settings: %0d table byte writes,",
               items_sent, settings_used, bytes_written);
      $display("%0d lookups in the table, %0d beyond it, %0d chain ends, %0d bad entries",
               lookups_inside, lookups_outside, chain_ends, bad_entries);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/fccs_pkg.sv
rtl/core/fccs_store.sv
rtl/core/fat_cluster_chain_step_top.sv
rtl/core/fccs_checker.sv
tb/sv/tb_fat_cluster_chain_step_top.sv
